// File: rtl/lpd_pkg.sv
// Package for the length-prefixed deframer: payload structs, phase and status codes.
// No dependencies; used by length_prefixed_deframer_core and lpd_checker.
package lpd_pkg;

  localparam int unsigned LenFieldBytes = 2;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrW     = $clog2(QueueDepth);
  localparam int unsigned QueueCntW     = $clog2(QueueDepth + 1);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_LONG  = 2'd2;

  localparam logic [1:0] REG_MIN_LENGTH = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd1;
  localparam logic [1:0] REG_BIG_ENDIAN = 2'd2;

  typedef enum logic [1:0] {
    PH_WAIT_LEN = 2'd0,
    PH_HELD_LEN = 2'd1,
    PH_BODY     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } lpd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       packet_first;
    logic       packet_last;
    logic       run_last;
  } lpd_out_t;

endpackage

// File: rtl/length_prefixed_deframer_core.sv
// Length-prefixed packet deframer: cuts a byte stream into packets with a 16-bit length.
// Depends on lpd_pkg for payload structs, phase and status codes.
// Each result is registered in the result queue; the held first length byte gives none.
// Throughput: one input byte per cycle while the queue has room; a length pair pushes two
// results into this four-entry queue, which drains one per cycle while out_ready is high.
// Reset: synchronous active-low rst_n clears phase, counters and queue, and loads defaults.
module length_prefixed_deframer_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lpd_pkg::lpd_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output lpd_pkg::lpd_out_t out_data,
  input  logic            cfg_psel,
  input  logic            cfg_penable,
  input  logic            cfg_pwrite,
  input  logic [3:0]      cfg_paddr,
  input  logic [31:0]     cfg_pwdata,
  output logic [31:0]     cfg_prdata,
  output logic            cfg_pready
);

  localparam int unsigned PW = lpd_pkg::QueuePtrW;
  localparam int unsigned CW = lpd_pkg::QueueCntW;

  logic [15:0] min_length_r;
  logic [15:0] max_length_r;
  logic        big_endian_r;

  lpd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [15:0]     remain_r, remain_nxt;
  logic            discard_r, discard_nxt;

  lpd_pkg::lpd_out_t queue_r [lpd_pkg::QueueDepth];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;

  logic            in_fire, out_fire, cfg_wr;
  logic [1:0]      n_push;
  lpd_pkg::lpd_out_t res0, res1;
  logic [15:0]     len;
  logic [1:0]      len_err;
  logic [15:0]     len_body;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[3:2])
      lpd_pkg::REG_MIN_LENGTH: cfg_prdata = {16'd0, min_length_r};
      lpd_pkg::REG_MAX_LENGTH: cfg_prdata = {16'd0, max_length_r};
      lpd_pkg::REG_BIG_ENDIAN: cfg_prdata = {31'd0, big_endian_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= 16'd10;
      max_length_r <= 16'd8192;
      big_endian_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        lpd_pkg::REG_MIN_LENGTH: min_length_r <= cfg_pwdata[15:0];
        lpd_pkg::REG_MAX_LENGTH: max_length_r <= cfg_pwdata[15:0];
        lpd_pkg::REG_BIG_ENDIAN: big_endian_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = queue_r[rd_ptr_r];
  assign in_ready  = (cnt_r <= CW'(lpd_pkg::QueueDepth - 2)) ||
                     ((cnt_r == CW'(lpd_pkg::QueueDepth - 1)) && out_fire);
  assign in_fire   = in_valid && in_ready;

  assign len = big_endian_r ? {held_r, in_data.rx_byte} : {in_data.rx_byte, held_r};
  assign len_body = len - 16'(lpd_pkg::LenFieldBytes);

  always_comb begin
    if (len < 16'(lpd_pkg::LenFieldBytes) || len < min_length_r) begin
      len_err = lpd_pkg::STATUS_SHORT;
    end else if (len > max_length_r) begin
      len_err = lpd_pkg::STATUS_LONG;
    end else begin
      len_err = lpd_pkg::STATUS_OK;
    end
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    held_nxt    = held_r;
    remain_nxt  = remain_r;
    discard_nxt = discard_r;
    if (in_fire) begin
      if (discard_r) begin
        if (in_data.chunk_last) begin
          discard_nxt = 1'b0;
        end
      end else begin
        unique case (phase_r)
          lpd_pkg::PH_HELD_LEN: begin
            if (len_err != lpd_pkg::STATUS_OK) begin
              phase_nxt   = lpd_pkg::PH_WAIT_LEN;
              remain_nxt  = 16'd0;
              discard_nxt = !in_data.chunk_last;
            end else begin
              remain_nxt = len_body;
              phase_nxt  = (len_body != 16'd0) ? lpd_pkg::PH_BODY : lpd_pkg::PH_WAIT_LEN;
            end
          end
          lpd_pkg::PH_BODY: begin
            if (remain_r <= 16'd1) begin
              remain_nxt = 16'd0;
              phase_nxt  = lpd_pkg::PH_WAIT_LEN;
            end else begin
              remain_nxt = remain_r - 16'd1;
            end
          end
          default: begin
            held_nxt  = in_data.rx_byte;
            phase_nxt = lpd_pkg::PH_HELD_LEN;
          end
        endcase
      end
    end
  end

  // results
  always_comb begin
    n_push = 2'd0;
    res0   = '0;
    res1   = '0;
    if (in_fire && !discard_r) begin
      unique case (phase_r)
        lpd_pkg::PH_HELD_LEN: begin
          if (len_err != lpd_pkg::STATUS_OK) begin
            n_push        = 2'd1;
            res0.status   = len_err;
            res0.run_last = 1'b1;
          end else begin
            n_push            = 2'd2;
            res0.out_byte     = held_r;
            res0.packet_first = 1'b1;
            res1.out_byte     = in_data.rx_byte;
            res1.packet_last  = (len_body == 16'd0);
            res1.run_last     = 1'b1;
          end
        end
        lpd_pkg::PH_BODY: begin
          n_push           = 2'd1;
          res0.out_byte    = in_data.rx_byte;
          res0.packet_last = (remain_r <= 16'd1);
          res0.run_last    = 1'b1;
        end
        default: n_push = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= lpd_pkg::PH_WAIT_LEN;
      held_r    <= 8'd0;
      remain_r  <= 16'd0;
      discard_r <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      held_r    <= held_nxt;
      remain_r  <= remain_nxt;
      discard_r <= discard_nxt;
      wr_ptr_r  <= wr_ptr_r + PW'(n_push);
      rd_ptr_r  <= rd_ptr_r + PW'(out_fire);
      cnt_r     <= cnt_r + CW'(n_push) - CW'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_r + PW'(1)] <= res1;
    end
  end

endmodule

// File: rtl/lpd_checker.sv
// Port-level checker for length_prefixed_deframer_core, bound into that module.
// Depends on lpd_pkg for the result struct and status codes.
module lpd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input lpd_pkg::lpd_out_t out_data
);

  // hold a stalled transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != lpd_pkg::STATUS_OK |->
      out_data.out_byte == 8'd0 && !out_data.packet_first &&
      !out_data.packet_last && out_data.run_last)
    else $error("malformed error result");

  a_first_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_first |->
      !out_data.run_last && !out_data.packet_last &&
      out_data.status == lpd_pkg::STATUS_OK)
    else $error("first byte not followed by second length byte");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.packet_last |-> out_data.run_last)
    else $error("packet end without run end");

endmodule

bind length_prefixed_deframer_core lpd_checker u_lpd_checker (.*);
